>>> hw/rtl/usbmidi_pkg.sv
// ----------------------------------------------------------------------------
// usbmidi_pkg
// Shared types and constants of the USB MIDI descriptor scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package usbmidi_pkg;

  // Descriptor and field codes
  localparam logic [7:0] DescInterface    = 8'd4;
  localparam logic [7:0] DescEndpoint     = 8'd5;
  localparam logic [7:0] ClassAudio       = 8'd1;
  localparam logic [7:0] SubclassMidi     = 8'd3;
  localparam logic [1:0] XferBulk         = 2'd2;
  localparam logic [7:0] IfaceMinLength   = 8'd9;
  localparam logic [7:0] EpMinLength      = 8'd7;
  localparam logic [7:0] HeaderLength     = 8'd2;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    STATUS_FOUND     = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_MALFORMED = 2'd2
  } status_e;

  // Position of a byte within its sub-descriptor
  typedef enum logic [2:0] {
    POS_LENGTH   = 3'd0,
    POS_TYPE     = 3'd1,
    POS_NUMBER   = 3'd2,
    POS_ATTR     = 3'd3,
    POS_LOW      = 3'd4,
    POS_HIGH     = 3'd5,
    POS_SUBCLASS = 3'd6,
    POS_REST     = 3'd7
  } pos_e;

  // Classified byte, front to back
  typedef struct packed {
    logic [7:0] data;
    pos_e       pos;
    logic [7:0] desc_len;
    logic [7:0] desc_type;
    logic       commit;   // last byte of its sub-descriptor
    logic       bad_len;  // type byte of a descriptor with length below 2
    logic       cutoff;   // stream ends inside a sub-descriptor
    logic       last;
  } op_t;

endpackage

`default_nettype wire

>>> hw/rtl/usbmidi_front.sv
// ----------------------------------------------------------------------------
// usbmidi_front
// Tracks the position in the sub-descriptor chain and classifies each byte.
// ----------------------------------------------------------------------------
`default_nettype none

module usbmidi_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             take_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             last_byte_i,
  output usbmidi_pkg::op_t      op_o
);

  logic [7:0] idx_q, idx_d;
  logic [7:0] len_q, len_d;
  logic [7:0] type_q, type_d;
  logic [8:0] idx_inc;
  logic       is_len, is_type, bad_len, commit;

  assign is_len  = (idx_q == 8'd0);
  assign is_type = (idx_q == 8'd1);
  assign idx_inc = {1'b0, idx_q} + 9'd1;
  assign bad_len = is_type && (len_q < usbmidi_pkg::HeaderLength);
  assign commit  = !is_len && !bad_len && (idx_inc >= {1'b0, len_q});

  always_comb begin
    len_d  = is_len  ? data_byte_i : len_q;
    type_d = is_type ? data_byte_i : type_q;
    if (is_len || bad_len) begin
      idx_d = 8'd1;
    end else if (commit) begin
      idx_d = 8'd0;
    end else begin
      idx_d = idx_inc[7:0];
    end
  end

  always_comb begin
    op_o.data      = data_byte_i;
    op_o.pos       = (idx_q > 8'd6) ? usbmidi_pkg::POS_REST
                                    : usbmidi_pkg::pos_e'(idx_q[2:0]);
    op_o.desc_len  = len_d;
    op_o.desc_type = type_d;
    op_o.commit    = commit;
    op_o.bad_len   = bad_len;
    op_o.cutoff    = last_byte_i && (idx_d >= 8'd2);
    op_o.last      = last_byte_i;
  end

  // Position restarts after the last byte of a stream
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      len_q  <= '0;
      type_q <= '0;
    end else if (take_i) begin
      if (last_byte_i) begin
        idx_q  <= '0;
        len_q  <= '0;
        type_q <= '0;
      end else begin
        idx_q  <= idx_d;
        len_q  <= len_d;
        type_q <= type_d;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/usbmidi_queue.sv
// ----------------------------------------------------------------------------
// usbmidi_queue
// Short queue of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module usbmidi_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire usbmidi_pkg::op_t push_op_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output usbmidi_pkg::op_t      head_o
);

  localparam int unsigned PtrW = $clog2(usbmidi_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(usbmidi_pkg::QueueDepth + 1);

  usbmidi_pkg::op_t mem_q [usbmidi_pkg::QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  assign full_o  = (count_q == CntW'(usbmidi_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(usbmidi_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(usbmidi_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue read while empty");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(usbmidi_pkg::QueueDepth))
    else $error("queue count out of range");

endmodule

`default_nettype wire

>>> hw/rtl/usbmidi_back.sv
// ----------------------------------------------------------------------------
// usbmidi_back
// Holds pending descriptor fields, commits sub-descriptors and builds the
// result into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module usbmidi_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             empty_i,
  input  wire usbmidi_pkg::op_t head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [1:0]            status_o,
  output logic [7:0]            interface_number_o,
  output logic [7:0]            alternate_setting_o,
  output logic [7:0]            in_endpoint_o,
  output logic [10:0]           in_max_packet_o,
  output logic [7:0]            out_endpoint_o,
  output logic [10:0]           out_max_packet_o
);

  // Scan state
  logic        mia_q, mia_d;
  logic        found_q, found_d;
  logic        frozen_q, frozen_d;
  logic        malformed_q, malformed_d;
  logic [7:0]  iface_q, iface_d;
  logic [7:0]  alt_q, alt_d;
  logic [7:0]  in_ep_q, in_ep_d;
  logic [10:0] in_max_q, in_max_d;
  logic [7:0]  out_ep_q, out_ep_d;
  logic [10:0] out_max_q, out_max_d;
  logic [7:0]  p_num_q, p_num_d;
  logic [7:0]  p_attr_q, p_attr_d;
  logic [7:0]  p_low_q, p_low_d;
  logic        p_match_q, p_match_d;
  logic [10:0] p_max_q, p_max_d;

  // Result register
  logic        out_valid_q;
  logic [1:0]  status_q;
  logic [7:0]  r_iface_q, r_alt_q, r_in_ep_q, r_out_ep_q;
  logic [10:0] r_in_max_q, r_out_max_q;

  logic        out_free, active, is_iface, is_bulk_ep;
  usbmidi_pkg::status_e status_d;

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = !empty_i && (!head_i.last || out_free);
  assign active   = !frozen_q && !malformed_q;

  // Field capture
  always_comb begin
    p_num_d   = p_num_q;
    p_attr_d  = p_attr_q;
    p_low_d   = p_low_q;
    p_match_d = p_match_q;
    p_max_d   = p_max_q;
    unique case (head_i.pos)
      usbmidi_pkg::POS_LENGTH: p_match_d = 1'b0;
      usbmidi_pkg::POS_NUMBER: p_num_d   = head_i.data;
      usbmidi_pkg::POS_ATTR:   p_attr_d  = head_i.data;
      usbmidi_pkg::POS_LOW:    p_low_d   = head_i.data;
      usbmidi_pkg::POS_HIGH: begin
        if (head_i.desc_type == usbmidi_pkg::DescEndpoint) begin
          p_max_d = {head_i.data[2:0], p_low_q};
        end
        p_low_d = head_i.data;
      end
      usbmidi_pkg::POS_SUBCLASS: begin
        p_match_d = (p_low_q == usbmidi_pkg::ClassAudio) &&
                    (head_i.data == usbmidi_pkg::SubclassMidi);
      end
      usbmidi_pkg::POS_TYPE, usbmidi_pkg::POS_REST: ;
      default: ;
    endcase
  end

  assign is_iface   = (head_i.desc_type == usbmidi_pkg::DescInterface) &&
                      (head_i.desc_len >= usbmidi_pkg::IfaceMinLength);
  assign is_bulk_ep = mia_q && (head_i.desc_type == usbmidi_pkg::DescEndpoint) &&
                      (head_i.desc_len >= usbmidi_pkg::EpMinLength) &&
                      (p_attr_d[1:0] == usbmidi_pkg::XferBulk);

  // Commit of a complete sub-descriptor
  always_comb begin
    mia_d     = mia_q;
    found_d   = found_q;
    frozen_d  = frozen_q;
    iface_d   = iface_q;
    alt_d     = alt_q;
    in_ep_d   = in_ep_q;
    in_max_d  = in_max_q;
    out_ep_d  = out_ep_q;
    out_max_d = out_max_q;
    if (active && head_i.commit) begin
      if (is_iface) begin
        if (found_q && (in_ep_q != 8'd0)) begin
          frozen_d = 1'b1;
        end else begin
          mia_d = p_match_d;
          if (p_match_d) begin
            found_d   = 1'b1;
            iface_d   = p_num_d;
            alt_d     = p_attr_d;
            in_ep_d   = '0;
            in_max_d  = '0;
            out_ep_d  = '0;
            out_max_d = '0;
          end
        end
      end else if (is_bulk_ep) begin
        if (p_num_d[7]) begin
          in_ep_d  = p_num_d;
          in_max_d = p_max_d;
        end else begin
          out_ep_d  = p_num_d;
          out_max_d = p_max_d;
        end
      end
    end
    malformed_d = malformed_q || (active && (head_i.bad_len || head_i.cutoff));
  end

  always_comb begin
    if (malformed_d) begin
      status_d = usbmidi_pkg::STATUS_MALFORMED;
    end else if (frozen_d || (found_d && (in_ep_d != 8'd0) && (in_max_d != 11'd0))) begin
      status_d = usbmidi_pkg::STATUS_FOUND;
    end else begin
      status_d = usbmidi_pkg::STATUS_NOT_FOUND;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mia_q       <= 1'b0;
      found_q     <= 1'b0;
      frozen_q    <= 1'b0;
      malformed_q <= 1'b0;
      iface_q     <= '0;
      alt_q       <= '0;
      in_ep_q     <= '0;
      in_max_q    <= '0;
      out_ep_q    <= '0;
      out_max_q   <= '0;
      p_num_q     <= '0;
      p_attr_q    <= '0;
      p_low_q     <= '0;
      p_match_q   <= 1'b0;
      p_max_q     <= '0;
    end else if (pop_o) begin
      if (head_i.last) begin
        mia_q       <= 1'b0;
        found_q     <= 1'b0;
        frozen_q    <= 1'b0;
        malformed_q <= 1'b0;
        iface_q     <= '0;
        alt_q       <= '0;
        in_ep_q     <= '0;
        in_max_q    <= '0;
        out_ep_q    <= '0;
        out_max_q   <= '0;
        p_num_q     <= '0;
        p_attr_q    <= '0;
        p_low_q     <= '0;
        p_match_q   <= 1'b0;
        p_max_q     <= '0;
      end else begin
        mia_q       <= mia_d;
        found_q     <= found_d;
        frozen_q    <= frozen_d;
        malformed_q <= malformed_d;
        iface_q     <= iface_d;
        alt_q       <= alt_d;
        in_ep_q     <= in_ep_d;
        in_max_q    <= in_max_d;
        out_ep_q    <= out_ep_d;
        out_max_q   <= out_max_d;
        // pending fields only move while the scan is live
        if (active && !head_i.bad_len) begin
          p_num_q   <= p_num_d;
          p_attr_q  <= p_attr_d;
          p_low_q   <= p_low_d;
          p_match_q <= p_match_d;
          p_max_q   <= p_max_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o && head_i.last) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Malformed result carries zero fields
  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.last) begin
      status_q    <= status_d;
      r_iface_q   <= malformed_d ? '0 : iface_d;
      r_alt_q     <= malformed_d ? '0 : alt_d;
      r_in_ep_q   <= malformed_d ? '0 : in_ep_d;
      r_in_max_q  <= malformed_d ? '0 : in_max_d;
      r_out_ep_q  <= malformed_d ? '0 : out_ep_d;
      r_out_max_q <= malformed_d ? '0 : out_max_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = status_q;
  assign interface_number_o  = r_iface_q;
  assign alternate_setting_o = r_alt_q;
  assign in_endpoint_o       = r_in_ep_q;
  assign in_max_packet_o     = r_in_max_q;
  assign out_endpoint_o      = r_out_ep_q;
  assign out_max_packet_o    = r_out_max_q;

  a_settled_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(frozen_q && malformed_q))
    else $error("scan both frozen and malformed");

  a_restart_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && head_i.last) |=> !found_q && !frozen_q && !malformed_q && out_valid_q)
    else $error("scan state not cleared after last item");

  a_malformed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q == usbmidi_pkg::STATUS_MALFORMED)) |->
      (r_iface_q == '0) && (r_in_ep_q == '0) && (r_out_ep_q == '0))
    else $error("malformed result with nonzero fields");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !(pop_o && head_i.last))
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

>>> hw/rtl/usb_midi_descriptor_scan.sv
// ----------------------------------------------------------------------------
// usb_midi_descriptor_scan
// Scans a USB configuration descriptor for a MIDI streaming interface.
// ----------------------------------------------------------------------------
// Input channel: one descriptor byte per item, last_byte_i marks the end of
// the stream. Output channel: one result item per stream, given for the
// last byte, with status and the interface and bulk endpoint details.
// The front stage classifies each byte by its position in the current
// sub-descriptor and writes it to a two-entry queue; the back stage commits
// complete sub-descriptors and loads the result register.
// Throughput: one byte per cycle while in_stall_o is low.
// A last byte passes through the queue to the back, which loads the result
// register when it pops that byte; the result is presented from there.
// A stalled result holds in the output register; bytes keep flowing until
// the queue fills behind a further last byte, then in_stall_o rises.
// Reset clears the scan state and the queue; after each last byte the scan
// restarts for a new stream.
// ----------------------------------------------------------------------------
`default_nettype none

module usb_midi_descriptor_scan (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [7:0]       interface_number_o,
  output logic [7:0]       alternate_setting_o,
  output logic [7:0]       in_endpoint_o,
  output logic [10:0]      in_max_packet_o,
  output logic [7:0]       out_endpoint_o,
  output logic [10:0]      out_max_packet_o
);

  usbmidi_pkg::op_t front_op, head_op;
  logic             take, q_full, q_empty, q_pop;

  assign in_stall_o = q_full;
  assign take       = in_valid_i && !q_full;

  usbmidi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .op_o        (front_op)
  );

  usbmidi_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (take),
    .push_op_i (front_op),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .empty_o   (q_empty),
    .head_o    (head_op)
  );

  usbmidi_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .empty_i             (q_empty),
    .head_i              (head_op),
    .pop_o               (q_pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_o            (status_o),
    .interface_number_o  (interface_number_o),
    .alternate_setting_o (alternate_setting_o),
    .in_endpoint_o       (in_endpoint_o),
    .in_max_packet_o     (in_max_packet_o),
    .out_endpoint_o      (out_endpoint_o),
    .out_max_packet_o    (out_max_packet_o)
  );

endmodule

`default_nettype wire
